@@ design/sbmpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmpd_pkg
// Shared widths, codes and reset values of the shot break median peak
// detector.
// ----------------------------------------------------------------------------
package sbmpd_pkg;

   localparam int DIST_W   = 20;
   localparam int FACTOR_W = 4;
   localparam int GAP_W    = 8;
   localparam int SHOT_W   = 16;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int DEF_WINDOW     = 9;
   localparam int DEF_RING_MULT  = 8;
   localparam int DEF_FRAME_BITS = 24;
   localparam int DEF_TIME_BITS  = 32;

   localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT    = 2'd2;

   localparam logic [FACTOR_W-1:0] RST_ENTRY_FACTOR = 4'd2;
   localparam logic [DIST_W-1:0]   RST_MIN_DISTANCE = 20'd65536;
   localparam logic [GAP_W-1:0]    RST_GAP_LIMIT    = 8'd10;

endpackage

@@ design/sbmpd_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmpd_ring
// Distance and mid-tag ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbmpd_ring #(
   parameter int DEPTH = sbmpd_pkg::DEF_WINDOW * sbmpd_pkg::DEF_RING_MULT,
   parameter int TAG_W = sbmpd_pkg::DEF_FRAME_BITS + sbmpd_pkg::DEF_TIME_BITS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [sbmpd_pkg::DIST_W-1:0]  wr_dist,
   input  logic [TAG_W-1:0]              wr_tag,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [sbmpd_pkg::DIST_W-1:0]  rd_dist,
   output logic [TAG_W-1:0]              rd_tag
);

   logic [sbmpd_pkg::DIST_W-1:0] dist_mem [DEPTH];
   logic [TAG_W-1:0]             tag_mem [DEPTH];
   logic [sbmpd_pkg::DIST_W-1:0] rd_dist_ff;
   logic [TAG_W-1:0]             rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= wr_dist;
         tag_mem[wr_addr]  <= wr_tag;
      end
      rd_dist_ff <= dist_mem[rd_addr];
      rd_tag_ff  <= tag_mem[rd_addr];
   end

   assign rd_dist = rd_dist_ff;
   assign rd_tag  = rd_tag_ff;

endmodule

@@ design/sbmpd_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmpd_median
// Upper median by rank counting: each candidate is swept against the ring
// through one shared comparator until its rank covers the middle position.
// ----------------------------------------------------------------------------
module sbmpd_median #(
   parameter int DEPTH = sbmpd_pkg::DEF_WINDOW * sbmpd_pkg::DEF_RING_MULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [$clog2(DEPTH)-1:0]       head,
   input  logic [$clog2(DEPTH+1)-1:0]     count,
   input  logic [sbmpd_pkg::DIST_W-1:0]   rd_data,
   output logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic                           done,
   output logic [sbmpd_pkg::DIST_W-1:0]   median
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] M_IDLE   = 3'd0;
   localparam logic [2:0] M_CAND   = 3'd1;
   localparam logic [2:0] M_CLATCH = 3'd2;
   localparam logic [2:0] M_SWEEP  = 3'd3;
   localparam logic [2:0] M_CHECK  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             cand_ff, cand_in;
   logic [CNT_W-1:0]             j_ff, j_in;
   logic [CNT_W-1:0]             less_ff, less_in;
   logic [CNT_W-1:0]             leq_ff, leq_in;
   logic                         pipe_ff, pipe_in;
   logic [sbmpd_pkg::DIST_W-1:0] cval_ff, cval_in;
   logic [sbmpd_pkg::DIST_W-1:0] med_ff, med_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             mid;

   function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
      return sum[IDX_W-1:0];
   endfunction

   assign mid = count >> 1;

   always_comb begin
      state_in = state_ff;
      cand_in  = cand_ff;
      j_in     = j_ff;
      less_in  = less_ff;
      leq_in   = leq_ff;
      pipe_in  = pipe_ff;
      cval_in  = cval_ff;
      med_in   = med_ff;
      done_in  = 1'b0;
      rd_addr  = wrap(head, cand_ff);
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               cand_in  = '0;
               state_in = M_CAND;
            end
         end
         M_CAND: begin
            state_in = M_CLATCH;
         end
         M_CLATCH: begin
            cval_in  = rd_data;
            j_in     = '0;
            less_in  = '0;
            leq_in   = '0;
            pipe_in  = 1'b0;
            state_in = M_SWEEP;
         end
         M_SWEEP: begin
            rd_addr = wrap(head, j_ff);
            if (pipe_ff) begin
               if (rd_data < cval_ff)  less_in = less_ff + 1'b1;
               if (rd_data <= cval_ff) leq_in  = leq_ff + 1'b1;
            end
            if (j_ff != count) begin
               j_in    = j_ff + 1'b1;
               pipe_in = 1'b1;
            end else begin
               pipe_in = 1'b0;
               if (!pipe_ff) state_in = M_CHECK;
            end
         end
         M_CHECK: begin
            if (less_ff <= mid && mid < leq_ff) begin
               med_in   = cval_ff;
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               cand_in  = cand_ff + 1'b1;
               state_in = M_CAND;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cand_ff <= cand_in;
      j_ff    <= j_in;
      less_ff <= less_in;
      leq_ff  <= leq_in;
      pipe_ff <= pipe_in;
      cval_ff <= cval_in;
      med_ff  <= med_in;
   end

   assign done   = done_ff;
   assign median = med_ff;

endmodule

@@ design/shot_break_median_peak_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shot_break_median_peak_detector_unit
// Shot break detector: tag window, distance rings, sliding upper median and
// peak tracking with shot emission on falling distance, gap or end of stream.
// ----------------------------------------------------------------------------
// Frame and drain words run the rank-counting median sweep over the single
//   ring read port, across the ring fill (up to WINDOW*RING_MULT entries).
// Throughput: one word at a time; req_tready is high only while idle.
// Reset: synchronous, clears the control state and returns the configuration registers to defaults.
// ----------------------------------------------------------------------------
module shot_break_median_peak_detector_unit #(
   parameter int WINDOW     = sbmpd_pkg::DEF_WINDOW,
   parameter int RING_MULT  = sbmpd_pkg::DEF_RING_MULT,
   parameter int FRAME_BITS = sbmpd_pkg::DEF_FRAME_BITS,
   parameter int TIME_BITS  = sbmpd_pkg::DEF_TIME_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // frame_number, frame_stamp, cut_distance
   input  logic [((FRAME_BITS+TIME_BITS+sbmpd_pkg::DIST_W+7)/8)*8-1:0] req_tdata,
   // cmd
   input  logic [sbmpd_pkg::CMD_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // shot_number, begin_frame, begin_stamp, finish_frame, finish_stamp, break_score
   output logic [((sbmpd_pkg::SHOT_W+2*(FRAME_BITS+TIME_BITS)+sbmpd_pkg::DIST_W+7)/8)*8-1:0]
                rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sbmpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbmpd_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int DIST_W = sbmpd_pkg::DIST_W;
   localparam int FW     = sbmpd_pkg::FACTOR_W;
   localparam int DEPTH  = WINDOW * RING_MULT;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TW_IDX = $clog2(WINDOW);
   localparam int TW_CNT = $clog2(WINDOW + 1);
   localparam int TAG_W  = FRAME_BITS + TIME_BITS;
   localparam int RSP_W  = ((sbmpd_pkg::SHOT_W + 2*TAG_W + DIST_W + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_PUSH  = 4'd2;
   localparam logic [3:0] S_PUSH2 = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_MED   = 4'd5;
   localparam logic [3:0] S_MIDRD = 4'd6;
   localparam logic [3:0] S_DEC   = 4'd7;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic [TIME_BITS-1:0]  stamp;
   } tag_type;

   logic [3:0]                 state_ff, state_in;
   logic [sbmpd_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   tag_type                    cur_ff, cur_in;
   logic [DIST_W-1:0]          dist_ff, dist_in;
   tag_type                    tag_win_ff [WINDOW];
   tag_type                    tag_win_in [WINDOW];
   logic [TW_IDX-1:0]          tw_head_ff, tw_head_in;
   logic [TW_CNT-1:0]          tw_count_ff, tw_count_in;
   logic [IDX_W-1:0]           dr_head_ff, dr_head_in;
   logic [CNT_W-1:0]           dr_count_ff, dr_count_in;
   logic                       sb_valid_ff, sb_valid_in;
   tag_type                    sb_ff, sb_in;
   logic                       pf_valid_ff, pf_valid_in;
   tag_type                    pf_ff, pf_in;
   logic                       peak_open_ff, peak_open_in;
   logic [DIST_W-1:0]          peak_value_ff, peak_value_in;
   tag_type                    peak_tag_ff, peak_tag_in;
   logic [sbmpd_pkg::SHOT_W-1:0] shot_ff, shot_in;
   logic [FW-1:0]              factor_ff;
   logic [DIST_W-1:0]          min_dist_ff;
   logic [sbmpd_pkg::GAP_W-1:0] gap_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;
   logic [DIST_W-1:0]          med_val_ff, med_val_in;

   logic                       out_busy;
   logic                       emit;
   tag_type                    emit_b, emit_f;
   logic [DIST_W-1:0]          emit_s;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr, rd_addr, med_addr, mid_addr;
   tag_type                    mid_tag;
   logic [DIST_W-1:0]          rd_dist;
   logic [TAG_W-1:0]           rd_tag;
   tag_type                    rd_tag_s;
   logic                       med_start, med_done;
   logic [DIST_W-1:0]          med_out;
   logic                       gap_hit;
   logic [FW-1:0]              f_eff;
   logic [DIST_W+FW-1:0]       thr;
   logic                       opening, open_n, closing;
   logic [DIST_W-1:0]          pv;
   tag_type                    pt;

   function automatic logic [IDX_W-1:0] dr_wrap(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [TW_IDX-1:0] tw_wrap(input logic [TW_IDX-1:0] base,
                                                 input logic [TW_CNT-1:0] ofs);
      logic [TW_CNT:0] sum;
      sum = (TW_CNT+1)'(base) + (TW_CNT+1)'(ofs);
      if (sum >= (TW_CNT+1)'(WINDOW)) sum = sum - (TW_CNT+1)'(WINDOW);
      return sum[TW_IDX-1:0];
   endfunction

   sbmpd_ring #(.DEPTH(DEPTH), .TAG_W(TAG_W)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_dist (dist_ff),
      .wr_tag  (mid_tag),
      .rd_addr (rd_addr),
      .rd_dist (rd_dist),
      .rd_tag  (rd_tag)
   );

   sbmpd_median #(.DEPTH(DEPTH)) u_median (
      .clock   (clock),
      .reset   (reset),
      .start   (med_start),
      .head    (dr_head_ff),
      .count   (dr_count_ff),
      .rd_data (rd_dist),
      .rd_addr (med_addr),
      .done    (med_done),
      .median  (med_out)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign mid_tag  = tag_win_ff[tw_wrap(tw_head_ff, tw_count_ff >> 1)];
   assign wr_addr  = (dr_count_ff < CNT_W'(DEPTH)) ? dr_wrap(dr_head_ff, dr_count_ff)
                                                   : dr_head_ff;
   assign wr_en    = (state_ff == S_PUSH2);
   assign mid_addr = dr_wrap(dr_head_ff, dr_count_ff >> 1);
   assign rd_addr  = (state_ff == S_MED) ? med_addr : mid_addr;
   assign rd_tag_s = rd_tag;

   assign gap_hit = pf_valid_ff && (cur_ff.frame > pf_ff.frame)
                    && ((cur_ff.frame - pf_ff.frame) > FRAME_BITS'(gap_ff));
   assign f_eff   = (factor_ff == '0) ? FW'(1) : factor_ff;
   assign thr     = (DIST_W+FW)'(med_val_ff) * (DIST_W+FW)'(f_eff);
   assign opening = !peak_open_ff && ((DIST_W+FW)'(rd_dist) > thr)
                    && (rd_dist > min_dist_ff);
   assign open_n  = peak_open_ff || opening;

   always_comb begin
      pv = opening ? rd_dist : peak_value_ff;
      pt = opening ? rd_tag_s : peak_tag_ff;
      if (open_n && rd_dist > pv) begin
         pv = rd_dist;
         pt = rd_tag_s;
      end
   end

   assign closing = open_n && (((DIST_W+1)'(rd_dist) <= {med_val_ff, 1'b0})
                               || (rd_dist < min_dist_ff));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      dist_in       = dist_ff;
      tag_win_in    = tag_win_ff;
      tw_head_in    = tw_head_ff;
      tw_count_in   = tw_count_ff;
      dr_head_in    = dr_head_ff;
      dr_count_in   = dr_count_ff;
      sb_valid_in   = sb_valid_ff;
      sb_in         = sb_ff;
      pf_valid_in   = pf_valid_ff;
      pf_in         = pf_ff;
      peak_open_in  = peak_open_ff;
      peak_value_in = peak_value_ff;
      peak_tag_in   = peak_tag_ff;
      shot_in       = shot_ff;
      med_val_in    = med_val_ff;
      med_start     = 1'b0;
      emit          = 1'b0;
      emit_b        = sb_ff;
      emit_f        = pf_ff;
      emit_s        = peak_value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               cur_in   = {req_tdata[FRAME_BITS-1:0],
                           req_tdata[TAG_W-1:FRAME_BITS]};
               dist_in  = req_tdata[TAG_W+DIST_W-1:TAG_W];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               sbmpd_pkg::CMD_FRAME: begin
                  if (!(gap_hit && out_busy)) begin
                     if (!sb_valid_ff) begin
                        sb_in       = cur_ff;
                        sb_valid_in = 1'b1;
                     end
                     if (gap_hit) begin
                        emit          = 1'b1;
                        emit_b        = sb_valid_ff ? sb_ff : cur_ff;
                        peak_tag_in   = pf_ff;
                        sb_in         = cur_ff;
                        tw_head_in    = '0;
                        tw_count_in   = '0;
                        dr_head_in    = '0;
                        dr_count_in   = '0;
                        peak_open_in  = 1'b0;
                        peak_value_in = '0;
                     end
                     state_in = S_PUSH;
                  end
               end
               sbmpd_pkg::CMD_DRAIN: begin
                  if (dr_count_ff != '0) begin
                     dr_head_in  = dr_wrap(dr_head_ff, CNT_W'(1));
                     dr_count_in = dr_count_ff - 1'b1;
                  end
                  state_in = S_CHK;
               end
               sbmpd_pkg::CMD_END: begin
                  if (!out_busy) begin
                     emit_b = sb_valid_ff ? sb_ff : pf_ff;
                     emit   = pf_valid_ff && (emit_b != pf_ff);
                     tw_head_in    = '0;
                     tw_count_in   = '0;
                     dr_head_in    = '0;
                     dr_count_in   = '0;
                     sb_valid_in   = 1'b0;
                     sb_in         = '0;
                     pf_valid_in   = 1'b0;
                     pf_in         = '0;
                     peak_open_in  = 1'b0;
                     peak_value_in = '0;
                     peak_tag_in   = '0;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_PUSH: begin
            if (tw_count_ff < TW_CNT'(WINDOW)) begin
               tag_win_in[tw_wrap(tw_head_ff, tw_count_ff)] = cur_ff;
               tw_count_in = tw_count_ff + 1'b1;
            end else begin
               tag_win_in[tw_head_ff] = cur_ff;
               tw_head_in = tw_wrap(tw_head_ff, TW_CNT'(1));
            end
            pf_in       = cur_ff;
            pf_valid_in = 1'b1;
            state_in    = S_PUSH2;
         end
         S_PUSH2: begin
            if (dr_count_ff < CNT_W'(DEPTH)) begin
               dr_count_in = dr_count_ff + 1'b1;
            end else begin
               dr_head_in = dr_wrap(dr_head_ff, CNT_W'(1));
            end
            state_in = S_CHK;
         end
         S_CHK: begin
            if (dr_count_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               med_start = 1'b1;
               state_in  = S_MED;
            end
         end
         S_MED: begin
            if (med_done) begin
               med_val_in = med_out;
               state_in   = S_MIDRD;
            end
         end
         S_MIDRD: begin
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!(closing && out_busy)) begin
               peak_open_in  = open_n && !closing;
               peak_value_in = pv;
               peak_tag_in   = pt;
               if (closing) begin
                  emit        = 1'b1;
                  emit_f      = pt;
                  emit_s      = pv;
                  sb_in       = pt;
                  sb_valid_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({emit_s, emit_f.stamp, emit_f.frame,
                                emit_b.stamp, emit_b.frame, shot_ff});
         shot_in      = shot_ff + 1'b1;
      end
      if (state_ff == S_EXEC && cmd_ff == sbmpd_pkg::CMD_END && !out_busy) begin
         shot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tw_head_ff    <= '0;
         tw_count_ff   <= '0;
         dr_head_ff    <= '0;
         dr_count_ff   <= '0;
         sb_valid_ff   <= 1'b0;
         sb_ff         <= '0;
         pf_valid_ff   <= 1'b0;
         pf_ff         <= '0;
         peak_open_ff  <= 1'b0;
         peak_value_ff <= '0;
         peak_tag_ff   <= '0;
         shot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         factor_ff     <= sbmpd_pkg::RST_ENTRY_FACTOR;
         min_dist_ff   <= sbmpd_pkg::RST_MIN_DISTANCE;
         gap_ff        <= sbmpd_pkg::RST_GAP_LIMIT;
      end else begin
         state_ff      <= state_in;
         tw_head_ff    <= tw_head_in;
         tw_count_ff   <= tw_count_in;
         dr_head_ff    <= dr_head_in;
         dr_count_ff   <= dr_count_in;
         sb_valid_ff   <= sb_valid_in;
         sb_ff         <= sb_in;
         pf_valid_ff   <= pf_valid_in;
         pf_ff         <= pf_in;
         peak_open_ff  <= peak_open_in;
         peak_value_ff <= peak_value_in;
         peak_tag_ff   <= peak_tag_in;
         shot_ff       <= shot_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               sbmpd_pkg::CSR_ENTRY_FACTOR: factor_ff   <= csr_data[FW-1:0];
               sbmpd_pkg::CSR_MIN_DISTANCE: min_dist_ff <= csr_data[DIST_W-1:0];
               sbmpd_pkg::CSR_GAP_LIMIT:    gap_ff      <= csr_data[sbmpd_pkg::GAP_W-1:0];
               default: begin
               end
            endcase
         end
      end
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      dist_ff     <= dist_in;
      tag_win_ff  <= tag_win_in;
      med_val_ff  <= med_val_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
